@@ sv/slrg_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and helper functions for the subtractive lagged random generator.
// Used by: subtractive_lagged_random_generator and its test bench. No dependencies.
package slrg_pkg;

   // Field widths
   localparam int unsigned VAL_W   = 30;
   localparam int unsigned FRAC_W  = 32;
   localparam int unsigned SEED_W  = 31;
   localparam int unsigned PTR_W   = 6;
   localparam int unsigned CNT_W   = 6;
   localparam int unsigned TBL_DEPTH = 56;

   // Generator constants
   localparam logic [VAL_W-1:0]  MODULUS     = 30'd1000000000;
   localparam logic [SEED_W-1:0] SEED_OFFSET = 31'd161803398;

   // Fraction reciprocal: ceil(2^82 / MODULUS); value * FRAC_RECIP >> 50 is exact
   // for every value below MODULUS. Applied as a low 26-bit and a high 27-bit half.
   localparam logic [52:0] FRAC_RECIP    = 53'd4835703278458517;
   localparam logic [26:0] FRAC_RECIP_LO = {1'b0, FRAC_RECIP[25:0]};
   localparam logic [26:0] FRAC_RECIP_HI = FRAC_RECIP[52:26];

   // Table geometry
   localparam logic [PTR_W-1:0] TBL_LAST    = 6'd55;
   localparam logic [PTR_W-1:0] TBL_FIRST   = 6'd1;
   localparam logic [PTR_W-1:0] FILL_STRIDE = 6'd21;
   localparam logic [PTR_W-1:0] LEAD_START  = 6'd0;
   localparam logic [PTR_W-1:0] TRAIL_START = 6'd31;
   localparam logic [PTR_W-1:0] LAG_UP      = 6'd31;
   localparam logic [PTR_W-1:0] WARM_SPLIT  = 6'd24;

   // Sequencer step counts (last step index)
   // Seed distance is below 2^31 < 3 * MODULUS, so two compare-subtract steps reduce it
   localparam logic [CNT_W-1:0] MOD_STEPS_LAST  = 6'd1;
   localparam logic [CNT_W-1:0] FILL_STEPS_LAST = 6'd53;
   localparam logic [CNT_W-1:0] FRAC_STEPS_LAST = 6'd1;
   localparam logic [1:0]       WARM_PASS_LAST  = 2'd3;

   // Request kinds
   localparam logic FUNC_DRAW   = 1'b0;
   localparam logic FUNC_RESEED = 1'b1;

   // a - b modulo MODULUS, both operands below MODULUS
   function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W:0]   diff;
      logic [VAL_W-1:0] res;
      diff = {1'b0, a} - {1'b0, b};
      if (diff[VAL_W]) begin
         res = diff[VAL_W-1:0] + MODULUS;
      end else begin
         res = diff[VAL_W-1:0];
      end
      return res;
   endfunction

   // Pointer advance, wrapping past the last entry back to the first
   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] res;
      if (p >= TBL_LAST) begin
         res = TBL_FIRST;
      end else begin
         res = p + TBL_FIRST;
      end
      return res;
   endfunction

   // Next fill slot: (slot + 21) mod 55
   function automatic logic [PTR_W-1:0] slot_advance(input logic [PTR_W-1:0] s);
      logic [PTR_W:0] sum;
      logic [PTR_W:0] res;
      sum = {1'b0, s} + {1'b0, FILL_STRIDE};
      if (sum >= {1'b0, TBL_LAST}) begin
         res = sum - {1'b0, TBL_LAST};
      end else begin
         res = sum;
      end
      return res[PTR_W-1:0];
   endfunction

endpackage

@@ sv/subtractive_lagged_random_generator.sv @@
`timescale 1ns / 1ps
// Draw: a request is taken only while idle, so a new draw waits until the last result is loaded;
// loading waits while the result side still holds off an earlier waiting result.
// A draw is the table read and write of the draw and the 2-step reciprocal multiply for the fraction.
// Reseed (or first draw after reset) adds a 2-step seed reduction, 54 fill writes,
// and 4 warm-up passes of 55 entries, each a read then a write over the table RAM port.
// Reset (synchronous, active high) clears the sequencer, pointers, seeded flag and
// output valid; the table is not cleared and is always rewritten by seeding before use.
// Top level of the subtractive lagged random generator; depends on slrg_pkg.
module subtractive_lagged_random_generator (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] seed, [31] zero pad
   input  logic        req_tuser,   // [0] func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [29:0] value, [61:30] fraction, [63:62] zero pad
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_MODR    = 9'b000000010,
      ST_FILL    = 9'b000000100,
      ST_WARM_RD = 9'b000001000,
      ST_WARM_WR = 9'b000010000,
      ST_DRAW_RD = 9'b000100000,
      ST_DRAW_WR = 9'b001000000,
      ST_FRAC    = 9'b010000000,
      ST_DELIVER = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Datapath registers
   logic [slrg_pkg::VAL_W-1:0]  rem_ff, rem_in;
   logic [slrg_pkg::FRAC_W-1:0] sh_ff, sh_in;
   logic [slrg_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [slrg_pkg::VAL_W-1:0]  prev_ff, prev_in;
   logic [slrg_pkg::VAL_W-1:0]  cur_ff, cur_in;
   logic [slrg_pkg::PTR_W-1:0]  slot_ff, slot_in;
   logic [slrg_pkg::PTR_W-1:0]  idx_ff, idx_in;
   logic [1:0]                  pass_ff, pass_in;
   logic [slrg_pkg::PTR_W-1:0]  lead_ff, lead_in;
   logic [slrg_pkg::PTR_W-1:0]  trail_ff, trail_in;
   logic                        seeded_ff, seeded_in;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [slrg_pkg::VAL_W-1:0]  rsp_value_ff;
   logic [slrg_pkg::FRAC_W-1:0] rsp_frac_ff;
   logic                        out_load;

   // Table RAM
   logic [slrg_pkg::VAL_W-1:0]  lag_mem [slrg_pkg::TBL_DEPTH];
   logic [slrg_pkg::VAL_W-1:0]  rd_a_ff, rd_b_ff;
   logic [slrg_pkg::PTR_W-1:0]  raddr_a, raddr_b;
   logic [slrg_pkg::PTR_W-1:0]  waddr;
   logic [slrg_pkg::VAL_W-1:0]  wdata;
   logic                        mem_we;

   // Shared units
   logic [slrg_pkg::VAL_W-1:0]  op_a, op_b, sub_res;
   logic                        red_ge;
   logic [slrg_pkg::FRAC_W-1:0] red_val;
   logic [26:0]                 mul_b;
   logic [56:0]                 mul_p, frac_sum;
   logic [slrg_pkg::SEED_W-1:0] seed_val, seed_dist;
   logic [slrg_pkg::PTR_W-1:0]  lead_adv, trail_adv, warm_j;

   // Seed distance from the offset
   assign seed_val  = req_tdata[slrg_pkg::SEED_W-1:0];
   assign seed_dist = (slrg_pkg::SEED_OFFSET >= seed_val) ? (slrg_pkg::SEED_OFFSET - seed_val)
                                                          : (seed_val - slrg_pkg::SEED_OFFSET);

   // Compare-subtract step for the seed reduction
   assign red_ge  = (sh_ff >= {2'b00, slrg_pkg::MODULUS});
   assign red_val = red_ge ? (sh_ff - {2'b00, slrg_pkg::MODULUS}) : sh_ff;

   // Fraction multiplier: low reciprocal half first, then high half plus carried bits
   assign mul_b    = (cnt_ff == '0) ? slrg_pkg::FRAC_RECIP_LO : slrg_pkg::FRAC_RECIP_HI;
   assign mul_p    = {27'b0, cur_ff} * {30'b0, mul_b};
   assign frac_sum = mul_p + {27'b0, rem_ff};

   // Modular subtract: shared by fill, warm-up and draw
   assign op_a    = (state_ff == ST_FILL) ? prev_ff : rd_a_ff;
   assign op_b    = (state_ff == ST_FILL) ? cur_ff  : rd_b_ff;
   assign sub_res = slrg_pkg::sub_mod(op_a, op_b);

   // Table read addresses
   assign lead_adv  = slrg_pkg::ptr_advance(lead_ff);
   assign trail_adv = slrg_pkg::ptr_advance(trail_ff);
   assign warm_j    = (idx_ff <= slrg_pkg::WARM_SPLIT) ? (idx_ff + slrg_pkg::LAG_UP)
                                                       : (idx_ff - slrg_pkg::WARM_SPLIT);
   assign raddr_a   = (state_ff == ST_WARM_RD) ? idx_ff : lead_adv;
   assign raddr_b   = (state_ff == ST_WARM_RD) ? warm_j : trail_adv;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      sh_in     = sh_ff;
      cnt_in    = cnt_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      pass_in   = pass_ff;
      lead_in   = lead_ff;
      trail_in  = trail_ff;
      seeded_in = seeded_ff;
      mem_we    = 1'b0;
      waddr     = idx_ff;
      wdata     = sub_res;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == slrg_pkg::FUNC_RESEED || !seeded_ff) begin
                  state_in = ST_MODR;
                  sh_in    = {1'b0, seed_dist};
                  cnt_in   = '0;
               end else begin
                  state_in = ST_DRAW_RD;
               end
            end
         end
         ST_MODR: begin
            sh_in  = red_val;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == slrg_pkg::MOD_STEPS_LAST) begin
               mem_we   = 1'b1;
               waddr    = slrg_pkg::TBL_LAST;
               wdata    = red_val[slrg_pkg::VAL_W-1:0];
               prev_in  = red_val[slrg_pkg::VAL_W-1:0];
               cur_in   = slrg_pkg::VAL_W'(1);
               slot_in  = slrg_pkg::FILL_STRIDE;
               cnt_in   = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_we  = 1'b1;
            waddr   = slot_ff;
            wdata   = cur_ff;
            cur_in  = sub_res;
            prev_in = cur_ff;
            slot_in = slrg_pkg::slot_advance(slot_ff);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == slrg_pkg::FILL_STEPS_LAST) begin
               idx_in   = slrg_pkg::TBL_FIRST;
               pass_in  = '0;
               state_in = ST_WARM_RD;
            end
         end
         ST_WARM_RD: begin
            state_in = ST_WARM_WR;
         end
         ST_WARM_WR: begin
            mem_we = 1'b1;
            waddr  = idx_ff;
            wdata  = sub_res;
            if (idx_ff == slrg_pkg::TBL_LAST) begin
               idx_in  = slrg_pkg::TBL_FIRST;
               pass_in = pass_ff + 1'b1;
               if (pass_ff == slrg_pkg::WARM_PASS_LAST) begin
                  seeded_in = 1'b1;
                  lead_in   = slrg_pkg::LEAD_START;
                  trail_in  = slrg_pkg::TRAIL_START;
                  state_in  = ST_DRAW_RD;
               end else begin
                  state_in = ST_WARM_RD;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_WARM_RD;
            end
         end
         ST_DRAW_RD: begin
            lead_in  = lead_adv;
            trail_in = trail_adv;
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            mem_we   = 1'b1;
            waddr    = lead_ff;
            wdata    = sub_res;
            cur_in   = sub_res;
            cnt_in   = '0;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               rem_in = mul_p[55:26];
            end else begin
               sh_in = frac_sum[55:24];
            end
            if (cnt_ff == slrg_pkg::FRAC_STEPS_LAST) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid: set on load, cleared when the transaction is taken
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lead_ff      <= slrg_pkg::LEAD_START;
         trail_ff     <= slrg_pkg::TRAIL_START;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lead_ff      <= lead_in;
         trail_ff     <= trail_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      cnt_ff  <= cnt_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      pass_ff <= pass_in;
      if (out_load) begin
         rsp_value_ff <= cur_ff;
         rsp_frac_ff  <= sh_ff;
      end
   end

   // Table RAM: one write, two registered reads
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lag_mem[waddr] <= wdata;
      end
      rd_a_ff <= lag_mem[raddr_a];
      rd_b_ff <= lag_mem[raddr_b];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_frac_ff, rsp_value_ff};

`ifndef ASSERT_OFF
   // Trail pointer always stays 31 positions ahead of the lead pointer around the ring
   a_ptr_lag: assert property (@(posedge clock) disable iff (reset)
      (lead_ff <= slrg_pkg::WARM_SPLIT) ? (trail_ff == lead_ff + slrg_pkg::LAG_UP)
                                        : (trail_ff == lead_ff - slrg_pkg::WARM_SPLIT))
      else $error("trail pointer out of step with lead pointer");

   // No draw before the table has been seeded
   a_draw_seeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_RD) |-> seeded_ff)
      else $error("draw started on an unseeded table");

   // A result only appears out of the delivery step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DELIVER))
      else $error("result valid raised outside delivery");

   // Delivered value stays below the modulus
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff < slrg_pkg::MODULUS))
      else $error("result value not reduced");
`endif

endmodule

@@ bench/subtractive_lagged_random_generator_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for subtractive_lagged_random_generator: a queue-fed request driver,
// a result monitor and an in-bench prediction of the 55-entry lag table and its draws.
// Depends on slrg_pkg (request kind codes) and the generator RTL.
module subtractive_lagged_random_generator_test;

   // Generator arithmetic, kept independent of the RTL package
   localparam longint unsigned DRAW_MODULUS = 64'd1000000000;
   localparam logic [30:0]     SEED_BASE    = 31'd161803398;
   localparam logic [30:0]     SEED_MAX     = 31'h7FFF_FFFF;
   localparam int unsigned     TABLE_LAST   = 55;
   localparam int unsigned     PTR_WRAP     = 56;
   localparam int unsigned     FILL_STEP    = 21;
   localparam int unsigned     TRAIL_LAG    = 30;
   localparam int unsigned     WARM_PASSES  = 4;
   localparam int unsigned     TRAIL_HOME   = 31;

   // Run shape
   localparam int unsigned RANDOM_ITEMS   = 800;
   localparam int unsigned HOLD_AT_RESULT = 300;
   localparam int unsigned HOLD_CYCLES    = 1500;
   localparam int unsigned SETTLE_CYCLES  = 80;
   localparam int unsigned MAX_REPORTS    = 50;

   typedef struct {
      logic        func;
      logic [30:0] seed;
      int unsigned gap;
      bit          drain;   // hold off until every pending draw has come back
   } draw_request_type;

   typedef struct {
      logic [29:0] value;
      logic [31:0] fraction;
   } draw_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [30:0] seed, [31] zero pad
   logic        req_tuser  = 1'b0; // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [29:0] value, [61:30] fraction, [63:62] zero pad

   draw_request_type pending_requests[$];
   draw_result_type  expected_draws[$];
   draw_request_type current_request;
   bit            request_loaded = 1'b0;
   bit            request_taken  = 1'b0;
   bit            result_taken   = 1'b0;
   int unsigned   result_count   = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   calm_requests  = 0;
   int unsigned   calm_results   = 0;
   int unsigned   stall_left     = 0;
   int unsigned   hold_left      = 0;

   // Predicted generator state
   logic [29:0] lag_entry [1:55];
   int unsigned lead_ptr  = 0;
   int unsigned trail_ptr = TRAIL_HOME;
   bit          is_seeded = 1'b0;

   subtractive_lagged_random_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // a - b modulo the modulus, both below the modulus
   function automatic logic [29:0] mod_diff(input logic [29:0] a, input logic [29:0] b);
      longint unsigned t;
      t = (longint'(a) + DRAW_MODULUS - longint'(b)) % DRAW_MODULUS;
      return t[29:0];
   endfunction

   function automatic int unsigned step_ptr(input int unsigned p);
      return (p + 1 >= PTR_WRAP) ? 1 : p + 1;
   endfunction

   // Next draw of the generator, seeding the table first when asked or never seeded
   task automatic predict_draw(input logic func, input logic [30:0] seed,
                               output draw_result_type res);
      longint unsigned span;
      longint unsigned scaled;
      logic [29:0]     prev;
      logic [29:0]     cur;
      logic [29:0]     v;
      int unsigned     slot;
      if (func == slrg_pkg::FUNC_RESEED || !is_seeded) begin
         span = (seed > SEED_BASE) ? longint'(seed - SEED_BASE) : longint'(SEED_BASE - seed);
         span = span % DRAW_MODULUS;
         prev = span[29:0];
         cur = 30'd1;
         lag_entry[TABLE_LAST] = prev;
         for (int i = 1; i < TABLE_LAST; i++) begin
            slot = (FILL_STEP * i) % TABLE_LAST;
            lag_entry[slot] = cur;
            cur = mod_diff(prev, cur);
            prev = lag_entry[slot];
         end
         // warm-up passes
         for (int k = 0; k < WARM_PASSES; k++) begin
            for (int i = 1; i <= TABLE_LAST; i++) begin
               lag_entry[i] = mod_diff(lag_entry[i], lag_entry[1 + (i + TRAIL_LAG) % TABLE_LAST]);
            end
         end
         lead_ptr = 0;
         trail_ptr = TRAIL_HOME;
         is_seeded = 1'b1;
      end
      lead_ptr = step_ptr(lead_ptr);
      trail_ptr = step_ptr(trail_ptr);
      v = mod_diff(lag_entry[lead_ptr], lag_entry[trail_ptr]);
      lag_entry[lead_ptr] = v;
      scaled = longint'(v) << 32;
      scaled = scaled / DRAW_MODULUS;
      res.value = v;
      res.fraction = scaled[31:0];
   endtask

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                  result_count, what, got, want);
      end
   endtask

   // Gaps come in random runs, with occasional stretches of back-to-back requests
   task automatic queue_request(input logic func, input logic [30:0] seed, input bit drain);
      draw_request_type r;
      r.func = func;
      r.seed = seed;
      r.drain = drain;
      if (calm_requests != 0) begin
         calm_requests--;
         r.gap = 0;
      end else begin
         r.gap = $urandom_range(0, 4);
         if ($urandom_range(0, 19) == 0) calm_requests = 30;
      end
      pending_requests.push_back(r);
   endtask

   // Sample both handshakes at the rising edge; check results before logging new requests
   always @(posedge clock) begin : watch_ports
      draw_result_type want;
      logic [29:0]  got_value;
      logic [31:0]  got_fraction;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_value = rsp_tdata[29:0];
            got_fraction = rsp_tdata[61:30];
            result_count++;
            result_taken = 1'b1;
            if (expected_draws.size() == 0) begin
               report_mismatch("result with no request pending", got_value, 0);
            end else begin
               want = expected_draws.pop_front();
               if (got_value != want.value) report_mismatch("value", got_value, want.value);
               if (got_fraction != want.fraction) begin
                  report_mismatch("fraction", got_fraction, want.fraction);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_draw(req_tuser, req_tdata[30:0], want);
            expected_draws.push_back(want);
            request_taken = 1'b1;
         end
      end
   end

   // Request driver: one transaction held until taken, then the next after its gap
   always @(negedge clock) begin : feed_requests
      logic offer;
      offer = 1'b0;
      if (!reset) begin
         if (request_taken) begin
            request_taken = 1'b0;
            request_loaded = 1'b0;
         end else if (request_loaded && req_tvalid) begin
            offer = 1'b1;
         end
         if (!offer) begin
            if (!request_loaded && pending_requests.size() != 0) begin
               current_request = pending_requests.pop_front();
               request_loaded = 1'b1;
            end
            if (request_loaded) begin
               if (current_request.drain && expected_draws.size() != 0) begin
                  offer = 1'b0;
               end else if (current_request.gap != 0) begin
                  current_request.gap--;
               end else begin
                  offer = 1'b1;
               end
            end
         end
      end
      req_tvalid <= offer;
      if (offer) begin
         req_tdata <= {1'b0, current_request.seed};
         req_tuser <= current_request.func;
      end
   end

   // Result pacing: random stall per transaction, calm stretches, one long hold-off
   always @(negedge clock) begin : pace_results
      logic accept;
      accept = 1'b0;
      if (!reset) begin
         if (result_taken) begin
            result_taken = 1'b0;
            if (calm_results != 0) begin
               calm_results--;
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, 4);
               if ($urandom_range(0, 15) == 0) calm_results = 40;
            end
            if (result_count == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
         end else if (stall_left != 0) begin
            stall_left--;
         end else begin
            accept = 1'b1;
         end
      end
      rsp_tready <= accept;
   end

   initial begin : stimulus
      int unsigned queued;
      int unsigned run_len;
      logic [31:0] rnd;
      logic [30:0] seed;

      // Directed: first draw seeds the table, seed field ignored on a seeded draw
      queue_request(slrg_pkg::FUNC_DRAW, 31'd0, 1'b1);
      queue_request(slrg_pkg::FUNC_DRAW, 31'd12345, 1'b0);
      // seed equal to the offset, largest seed, seed above offset by exactly the modulus
      queue_request(slrg_pkg::FUNC_RESEED, SEED_BASE, 1'b0);
      queue_request(slrg_pkg::FUNC_DRAW, SEED_MAX, 1'b0);
      queue_request(slrg_pkg::FUNC_RESEED, SEED_MAX, 1'b1);
      queue_request(slrg_pkg::FUNC_DRAW, 31'd0, 1'b0);
      queue_request(slrg_pkg::FUNC_RESEED, 31'd0, 1'b0);
      queue_request(slrg_pkg::FUNC_RESEED, 31'd1161803398, 1'b0);
      queue_request(slrg_pkg::FUNC_RESEED, SEED_BASE - 31'd1, 1'b0);
      queue_request(slrg_pkg::FUNC_RESEED, SEED_BASE + 31'd1, 1'b0);
      queue_request(slrg_pkg::FUNC_RESEED, 31'd1, 1'b0);
      for (int i = 0; i < 14; i++) begin
         queue_request(slrg_pkg::FUNC_DRAW, (i % 2 == 0) ? 31'h2AAA_AAAA : 31'h5555_5555,
                       1'b0);
      end

      // Random: reseed followed by a run of draws, some long enough to wrap both pointers
      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         rnd = $urandom();
         case ($urandom_range(0, 7))
            0: seed = SEED_BASE;
            1: seed = SEED_MAX;
            2: seed = 31'd0;
            3: seed = SEED_BASE + 31'($urandom_range(0, 2)) - 31'd1;
            default: seed = rnd[30:0];
         endcase
         queue_request(slrg_pkg::FUNC_RESEED, seed, $urandom_range(0, 9) == 0);
         queued++;
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 25);
         for (int j = 0; j < run_len && queued < RANDOM_ITEMS; j++) begin
            rnd = $urandom();
            queue_request(slrg_pkg::FUNC_DRAW, rnd[30:0], $urandom_range(0, 49) == 0);
            queued++;
         end
      end

      // Wait for the last request to go in and every draw to come back
      while (pending_requests.size() != 0 || request_loaded) @(posedge clock);
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_draws.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
